### hdl/idea_pkg.sv
// Shared types and constants for the IDEA block encryption pipeline.
// Depends on nothing; every other file imports it.
`default_nettype none
package idea_pkg;

  localparam int WORD_W = 16;
  localparam int KEY_W = 64;
  localparam int IDEA_ROUND_COUNT = 8;
  localparam int ROUND_KEYS = 6;
  localparam int FINAL_KEYS = 4;
  localparam int GROUP_KEYS = 8;
  localparam int KEY_ROT = 25;
  localparam int FULL_KEY_W = 2 * KEY_W;

  localparam logic CFG_KEY_HIGH = 1'b0;
  localparam logic CFG_KEY_LOW = 1'b1;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [3:0][WORD_W-1:0] block_t;

  typedef struct packed {
    word_t w0;
    word_t w1;
    word_t w2;
    word_t w3;
  } plain_t;

  typedef struct packed {
    word_t w0;
    word_t w1;
    word_t w2;
    word_t w3;
  } cipher_t;

endpackage
`default_nettype wire

### hdl/idea_mul.sv
// Multiplier modulo 65537 with the IDEA convention that zero stands for 65536.
// Depends on idea_pkg.
`default_nettype none
module idea_mul
  import idea_pkg::*;
(
  input  wire word_t a,
  input  wire word_t b,
  output word_t      p
);

  logic [2*WORD_W-1:0] prod;
  word_t               lo;
  word_t               hi;

  assign prod = a * b;
  assign lo = prod[WORD_W-1:0];
  assign hi = prod[2*WORD_W-1:WORD_W];

  always_comb begin
    if (a == '0) begin
      p = word_t'(1) - b;
    end else if (b == '0) begin
      p = word_t'(1) - a;
    end else begin
      p = lo - hi + word_t'(lo < hi);
    end
  end

endmodule
`default_nettype wire

### hdl/idea_round.sv
// IDEA round: three register stages holding two, one and one multiplies.
// Depends on idea_pkg and idea_mul.
`default_nettype none
module idea_round
  import idea_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  input  wire block_t in_data,
  input  wire word_t  k0,
  input  wire word_t  k1,
  input  wire word_t  k2,
  input  wire word_t  k3,
  input  wire word_t  k4,
  input  wire word_t  k5,
  input  wire         down_adv,
  output logic        up_adv,
  output logic        out_valid,
  output block_t      out_data
);

  logic  v1, v2, v3;
  logic  en1, en2, en3;
  word_t a_mul, d_mul, g_mul, i_mul;
  word_t a1, b1, c1, d1;
  word_t a2, b2, c2, d2, g2;
  word_t h, j;
  block_t res;

  assign en3 = !v3 || down_adv;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign up_adv = en1;

  idea_mul u_mul_a (.a(in_data[0]), .b(k0), .p(a_mul));
  idea_mul u_mul_d (.a(in_data[3]), .b(k3), .p(d_mul));
  idea_mul u_mul_g (.a(a1 ^ c1), .b(k4), .p(g_mul));

  assign h = (b2 ^ d2) + g2;
  idea_mul u_mul_i (.a(h), .b(k5), .p(i_mul));
  assign j = g2 + i_mul;

  assign res[0] = a2 ^ i_mul;
  assign res[1] = c2 ^ i_mul;
  assign res[2] = b2 ^ j;
  assign res[3] = d2 ^ j;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      a1 <= a_mul;
      b1 <= in_data[1] + k1;
      c1 <= in_data[2] + k2;
      d1 <= d_mul;
    end
    if (en2 && v1) begin
      a2 <= a1;
      b2 <= b1;
      c2 <= c1;
      d2 <= d1;
      g2 <= g_mul;
    end
    if (en3 && v2) begin
      out_data <= res;
    end
  end

  assign out_valid = v3;

endmodule
`default_nettype wire

### hdl/idea_final.sv
// Output transform stage of IDEA, registered, feeding the result port.
// Depends on idea_pkg and idea_mul.
`default_nettype none
module idea_final
  import idea_pkg::*;
(
  input  wire          clk,
  input  wire          rst,
  input  wire          in_valid,
  input  wire block_t  in_data,
  input  wire word_t   k0,
  input  wire word_t   k1,
  input  wire word_t   k2,
  input  wire word_t   k3,
  input  wire          out_stall,
  output logic         up_adv,
  output logic         out_valid,
  output cipher_t      out_data
);

  logic  en;
  word_t m0, m3;

  assign en = !out_valid || !out_stall;
  assign up_adv = en;

  idea_mul u_mul_0 (.a(in_data[0]), .b(k0), .p(m0));
  idea_mul u_mul_3 (.a(in_data[3]), .b(k3), .p(m3));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      out_data.w0 <= m0;
      out_data.w1 <= in_data[2] + k1;
      out_data.w2 <= in_data[1] + k2;
      out_data.w3 <= m3;
    end
  end

endmodule
`default_nettype wire

### hdl/idea_block_encrypt_top.sv
// IDEA encryption pipeline: three stages per round and one for the output transform,
// with two multiplies in each round's first stage and in the output stage, one in the others.
// One block per cycle unless stalled; a stalled result lets earlier stages fill bubbles.
// Synchronous reset clears all stage valid bits and both key registers to zero.
// Depends on idea_pkg, idea_round, idea_final and idea_mul.
`default_nettype none
module idea_block_encrypt_top
  import idea_pkg::*;
#(
  parameter int ROUND_COUNT = IDEA_ROUND_COUNT
) (
  input  wire             clk,
  input  wire             rst,
  input  wire             plain_valid,
  output logic            plain_stall,
  input  wire plain_t     plain,
  output logic            cipher_valid,
  input  wire             cipher_stall,
  output cipher_t         cipher,
  input  wire             cfg_we,
  input  wire             cfg_index,
  input  wire [KEY_W-1:0] cfg_data
);

  localparam int SUBKEYS = ROUND_KEYS * ROUND_COUNT + FINAL_KEYS;

  logic [KEY_W-1:0]        key_high;
  logic [KEY_W-1:0]        key_low;
  logic [2*FULL_KEY_W-1:0] key_dbl;
  word_t                   sk [SUBKEYS];
  block_t                  dat [ROUND_COUNT+1];
  logic                    val [ROUND_COUNT+1];
  logic                    adv [ROUND_COUNT+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KEY_HIGH: key_high <= cfg_data;
        CFG_KEY_LOW:  key_low <= cfg_data;
        default:      key_low <= key_low;
      endcase
    end
  end

  assign key_dbl = {key_high, key_low, key_high, key_low};

  for (genvar s = 0; s < SUBKEYS; s++) begin : g_subkey
    localparam int Grp = s / GROUP_KEYS;
    localparam int Pos = s % GROUP_KEYS;
    localparam int Rot = (KEY_ROT * Grp) % FULL_KEY_W;
    assign sk[s] = key_dbl[2*FULL_KEY_W-1-Rot-WORD_W*Pos -: WORD_W];
  end

  assign dat[0] = {plain.w3, plain.w2, plain.w1, plain.w0};
  assign val[0] = plain_valid;
  assign plain_stall = !adv[0];

  for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
    idea_round u_round (
      .clk      (clk),
      .rst      (rst),
      .in_valid (val[r]),
      .in_data  (dat[r]),
      .k0       (sk[ROUND_KEYS*r]),
      .k1       (sk[ROUND_KEYS*r+1]),
      .k2       (sk[ROUND_KEYS*r+2]),
      .k3       (sk[ROUND_KEYS*r+3]),
      .k4       (sk[ROUND_KEYS*r+4]),
      .k5       (sk[ROUND_KEYS*r+5]),
      .down_adv (adv[r+1]),
      .up_adv   (adv[r]),
      .out_valid(val[r+1]),
      .out_data (dat[r+1])
    );
  end

  idea_final u_final (
    .clk      (clk),
    .rst      (rst),
    .in_valid (val[ROUND_COUNT]),
    .in_data  (dat[ROUND_COUNT]),
    .k0       (sk[ROUND_KEYS*ROUND_COUNT]),
    .k1       (sk[ROUND_KEYS*ROUND_COUNT+1]),
    .k2       (sk[ROUND_KEYS*ROUND_COUNT+2]),
    .k3       (sk[ROUND_KEYS*ROUND_COUNT+3]),
    .out_stall(cipher_stall),
    .up_adv   (adv[ROUND_COUNT]),
    .out_valid(cipher_valid),
    .out_data (cipher)
  );

  // Input stall can only come from a full pipeline behind a stalled result.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    plain_stall |-> cipher_valid && cipher_stall && val[ROUND_COUNT])
    else $error("input stalled while the pipeline has room");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !cipher_valid)
    else $error("result valid right after reset");

  a_no_stall_free: assert property (@(posedge clk) disable iff (rst)
    !cipher_stall |-> !plain_stall)
    else $error("input stalled while results drain");

endmodule
`default_nettype wire
